FILE: rtl/core/cmsa_pkg.sv
// Shared constants and types for the constant multiply shift-add planner.
package cmsa_pkg;

	localparam int MULT_WIDTH_DEF = 32;
	localparam int SHIFT_W        = 6;

	typedef logic [SHIFT_W-1:0] shift_t;

	// Result of the serial magnitude scan, handed to the term emitter.
	typedef struct packed {
		logic   neg;      // constant was negative
		shift_t add_cnt;  // set bits of the magnitude
		shift_t sub_top;  // set bits of 2^(top+1) - magnitude
		shift_t top;      // position of the magnitude's top set bit
	} scan_info_t;

	typedef struct packed {
		logic active;  // emitter is working through a run
		logic finish;  // last term of the run moves into the output register
	} emit_stat_t;

endpackage

FILE: rtl/core/cmsa_if.sv
// Handshake interfaces for the constant item and the term item.
interface cmsa_in_if import cmsa_pkg::*; #(
	parameter int MULT_WIDTH = MULT_WIDTH_DEF
);
	logic                  valid;
	logic                  ready;
	logic [MULT_WIDTH-1:0] multiplier;

	modport source (output valid, output multiplier, input ready);
	modport sink   (input valid, input multiplier, output ready);
endinterface

interface cmsa_out_if import cmsa_pkg::*;;
	logic   valid;
	logic   ready;
	logic   zero_product;
	shift_t shift_amount;
	logic   subtract_term;
	logic   negate_result;
	logic   last_term;

	modport source (output valid, output zero_product, output shift_amount,
		output subtract_term, output negate_result, output last_term, input ready);
	modport sink   (input valid, input zero_product, input shift_amount,
		input subtract_term, input negate_result, input last_term, output ready);
endinterface

FILE: rtl/core/cmsa_scan.sv
// Bit-serial scan: magnitude, its complement to the next power of two, counts.
module cmsa_scan import cmsa_pkg::*; #(
	parameter int MULT_WIDTH = MULT_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [MULT_WIDTH-1:0] multiplier,
	output logic                  done,
	output scan_info_t            info,
	output logic [MULT_WIDTH-1:0] mag,
	output logic [MULT_WIDTH-1:0] rest
);
	localparam int CNT_W = $clog2(MULT_WIDTH);

	logic                  run_q;
	logic                  done_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [MULT_WIDTH-1:0] data_q;
	logic [MULT_WIDTH-1:0] mag_q;
	logic [MULT_WIDTH-1:0] rest_q;
	logic                  vseen_q;
	logic                  mseen_q;
	shift_t                rest_cnt_q;
	scan_info_t            info_q;

	logic   vb;
	logic   mb;
	logic   rb;
	shift_t rc;
	logic   last_bit;

	// negate LSB first: flip every bit above the lowest set one
	assign vb       = data_q[0];
	assign mb       = vb ^ (info_q.neg & vseen_q);
	assign rb       = mb ^ mseen_q;
	assign rc       = rest_cnt_q + shift_t'(rb);
	assign last_bit = (cnt_q == CNT_W'(MULT_WIDTH - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= run_q && last_bit;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (last_bit) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			data_q         <= multiplier;
			info_q.neg     <= multiplier[MULT_WIDTH-1];
			info_q.add_cnt <= '0;
			info_q.sub_top <= '0;
			info_q.top     <= '0;
			rest_cnt_q     <= '0;
			vseen_q        <= 1'b0;
			mseen_q        <= 1'b0;
		end else if (run_q) begin
			data_q         <= {1'b0, data_q[MULT_WIDTH-1:1]};
			mag_q          <= {mb, mag_q[MULT_WIDTH-1:1]};
			rest_q         <= {rb, rest_q[MULT_WIDTH-1:1]};
			vseen_q        <= vseen_q | vb;
			mseen_q        <= mseen_q | mb;
			rest_cnt_q     <= rc;
			info_q.add_cnt <= info_q.add_cnt + shift_t'(mb);
			// rest bits above the top bit do not count: snapshot at each set bit
			if (mb) begin
				info_q.sub_top <= rc;
				info_q.top     <= shift_t'(cnt_q);
			end
		end
	end

	assign done = done_q;
	assign info = info_q;
	assign mag  = mag_q;
	assign rest = rest_q;

endmodule

FILE: rtl/core/cmsa_emit.sv
// Term emitter: picks the shorter form and walks its bits into the output register.
module cmsa_emit import cmsa_pkg::*; #(
	parameter int MULT_WIDTH = MULT_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  scan_info_t            info,
	input  logic [MULT_WIDTH-1:0] mag,
	input  logic [MULT_WIDTH-1:0] rest,
	output emit_stat_t            stat,
	cmsa_out_if.source            term
);
	logic                  active_q;
	logic                  zero_q;
	logic                  lead_q;
	logic                  subf_q;
	logic                  neg_q;
	shift_t                top_q;
	shift_t                rem_q;
	shift_t                pos_q;
	logic [MULT_WIDTH-1:0] vec_q;

	logic   ovalid_q;
	logic   zp_q;
	shift_t shift_q;
	logic   sub_q;
	logic   negr_q;
	logic   last_q;

	logic zero_w;
	logic subf_w;
	logic bit_w;
	logic can_load;
	logic step;
	logic emit;
	logic scan_step;
	logic last_w;
	logic finish;

	assign zero_w    = (info.add_cnt == '0);
	assign subf_w    = ({1'b0, info.sub_top} + 7'd1) < {1'b0, info.add_cnt};
	// add form walks up from bit 0, subtract form walks down from the top;
	// the serial complement leaves ones above the top bit, which are no terms
	assign bit_w     = subf_q ? (vec_q[MULT_WIDTH-1] && (pos_q <= top_q)) : vec_q[0];
	assign can_load  = !ovalid_q || term.ready;
	assign step      = active_q && can_load;
	assign emit      = step && (zero_q || lead_q || bit_w);
	assign scan_step = step && !zero_q && !lead_q;
	assign last_w    = zero_q || (rem_q == shift_t'(1));
	assign finish    = emit && last_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			if (start) begin
				active_q <= 1'b1;
			end else if (finish) begin
				active_q <= 1'b0;
			end
			if (emit) begin
				ovalid_q <= 1'b1;
			end else if (term.ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			zero_q <= zero_w;
			lead_q <= subf_w;
			subf_q <= subf_w;
			neg_q  <= info.neg;
			top_q  <= info.top;
			rem_q  <= subf_w ? info.sub_top + shift_t'(1) : info.add_cnt;
			pos_q  <= subf_w ? shift_t'(MULT_WIDTH - 1) : '0;
			vec_q  <= subf_w ? rest : mag;
		end else begin
			if (step && lead_q) begin
				lead_q <= 1'b0;
			end
			if (emit) begin
				rem_q <= rem_q - shift_t'(1);
			end
			if (scan_step) begin
				if (subf_q) begin
					vec_q <= {vec_q[MULT_WIDTH-2:0], 1'b0};
					pos_q <= pos_q - shift_t'(1);
				end else begin
					vec_q <= {1'b0, vec_q[MULT_WIDTH-1:1]};
					pos_q <= pos_q + shift_t'(1);
				end
			end
		end
		if (emit) begin
			zp_q    <= zero_q;
			shift_q <= zero_q ? '0 : (lead_q ? top_q + shift_t'(1) : pos_q);
			sub_q   <= !zero_q && !lead_q && subf_q;
			negr_q  <= !zero_q && neg_q;
			last_q  <= last_w;
		end
	end

	assign stat.active        = active_q;
	assign stat.finish        = finish;
	assign term.valid         = ovalid_q;
	assign term.zero_product  = zp_q;
	assign term.shift_amount  = shift_q;
	assign term.subtract_term = sub_q;
	assign term.negate_result = negr_q;
	assign term.last_term     = last_q;

endmodule

FILE: rtl/core/constant_multiply_shift_add_plan.sv
// Top level of the constant multiply shift-add planner.
//
//  channel   dir  payload                                                  item
//  operand   in   multiplier[MULT_WIDTH]                                   one constant
//  term      out  zero_product, shift_amount[6], subtract_term,            one shift term
//                 negate_result, last_term
//
//  Flow: a constant is scanned one bit a cycle to form its magnitude, the
//  complement to the next power of two and both popcounts; the emitter then
//  walks one bit a cycle, lead term included, unless the output stalls.
//  Reset: arst_n clears all control; no item is pending after reset.
//  Stalls: a full output register with term.ready low freezes the emitter;
//  the next constant is taken once the last term is in the output register.
module constant_multiply_shift_add_plan import cmsa_pkg::*; #(
	parameter int MULT_WIDTH = MULT_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	cmsa_in_if.sink     operand,
	cmsa_out_if.source  term
);
	logic                  busy_q;
	logic                  accept;
	logic                  scan_done;
	scan_info_t            info;
	logic [MULT_WIDTH-1:0] mag;
	logic [MULT_WIDTH-1:0] rest;
	emit_stat_t            estat;

	// one constant in flight, from acceptance until its last term is registered
	assign operand.ready = !busy_q;
	assign accept        = operand.valid && !busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (accept) begin
			busy_q <= 1'b1;
		end else if (estat.finish) begin
			busy_q <= 1'b0;
		end
	end

	cmsa_scan #(
		.MULT_WIDTH (MULT_WIDTH)
	) u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (accept),
		.multiplier (operand.multiplier),
		.done       (scan_done),
		.info       (info),
		.mag        (mag),
		.rest       (rest)
	);

	cmsa_emit #(
		.MULT_WIDTH (MULT_WIDTH)
	) u_emit (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (scan_done),
		.info   (info),
		.mag    (mag),
		.rest   (rest),
		.stat   (estat),
		.term   (term)
	);

	// scan results only appear for an accepted constant
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		scan_done |-> busy_q)
		else $error("scan finished with no constant in flight");

	// emitter must be idle when a new analysis is handed over
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		scan_done |-> !estat.active)
		else $error("scan result arrived while emitter still running");

	// a run only ends for the constant in flight
	a_finish_busy: assert property (@(posedge clk) disable iff (!arst_n)
		estat.finish |-> busy_q && estat.active)
		else $error("run finished with no constant in flight");

	// the final term is presented right after the run ends
	a_finish_out: assert property (@(posedge clk) disable iff (!arst_n)
		estat.finish |=> term.valid && term.last_term)
		else $error("last term not presented after run end");

endmodule
